// ===== sv/stp_pkg.sv =====
// Shared types and constants of the stereo timestamp pairer.
package stp_pkg;

  localparam int unsigned QueueDepthDefault = 16;
  localparam int unsigned TimeW   = 64;
  localparam int unsigned TagW    = 8;
  localparam int unsigned DropW   = 5;
  localparam int unsigned TolW    = 32;
  localparam int unsigned EntryW  = TimeW + TagW;
  localparam int unsigned SumW    = TimeW + 1;
  localparam int unsigned InDataW  = 72;
  localparam int unsigned OutDataW = 96;

  localparam logic [TolW-1:0] TolReset = 32'd1500000;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_DIFF,
    ST_TOL,
    ST_MID,
    ST_OUT
  } stp_state_e;

  typedef enum logic [1:0] {
    ALU_SUB,
    ALU_TOL,
    ALU_ADD
  } alu_op_e;

  typedef struct packed {
    logic push;
    logic pop;
  } fifo_ctrl_t;

endpackage

// ===== sv/stereo_timestamp_pairer_top.sv =====
// Top level of the stereo timestamp pairer: sequencer, queues and result register.
//
// Input stream (s_axis): one frame notice per transfer; tuser selects the camera
// (0 left, 1 right), tdata carries the timestamp and the frame tag. The notice is
// pushed into that side's queue; a push into a full queue discards its oldest entry
// and flags overflow.
// Output stream (m_axis): exactly one result per input transfer, carrying the
// pair (if any), the midpoint time, the per-side drop counts and the overflow flag.
// Sequence: after an input transfer each head comparison round steps through the
// head RAM read, the subtract and the tolerance test on the shared 65-bit adder,
// and repeats after each dropped head; a match adds a midpoint step and a final
// step loads the result register. s_axis_tready is high only while the sequencer
// is idle, so one notice is processed at a time and the next transfer can follow
// in the cycle after the result is loaded.
// The result register lets the next notice in while a result waits; if the
// receiver still stalls when the next result is ready, the sequencer holds.
// Reset empties both queues and sets the tolerance to 1500000 ns; cfg_we_i writes
// the tolerance; use it only while the block is idle (the block does not enforce this).
module stereo_timestamp_pairer_top
  import stp_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QueueDepthDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [TolW-1:0]     cfg_wdata_i,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // [63:0] time_ns, [71:64] frame_tag
  input  logic [InDataW-1:0]  s_axis_tdata,
  // [0] cam_side
  input  logic                s_axis_tuser,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // [7:0] left_tag, [15:8] right_tag, [79:16] mid_time_ns, [84:80] left_dropped,
  // [89:85] right_dropped, [90] overflow, [95:91] zero
  output logic [OutDataW-1:0] m_axis_tdata,
  // [0] pair_valid
  output logic                m_axis_tuser
);

  stp_state_e state_q, state_d;

  logic [TolW-1:0]  tol_q;
  logic [SumW-1:0]  diff_q;
  logic [SumW-1:0]  alu_sum;
  alu_op_e          alu_op;
  logic [DropW-1:0] ldrop_q, rdrop_q;
  logic             ovf_q, paired_q;
  logic [TagW-1:0]  ltag_q, rtag_q;
  logic [TimeW-1:0] mid_q;

  logic                m_valid_q;
  logic [OutDataW-1:0] m_data_q;
  logic                m_user_q;

  fifo_ctrl_t        lf_ctrl, rf_ctrl;
  logic [EntryW-1:0] l_head, r_head;
  logic              l_full, r_full, l_nonempty, r_nonempty;

  logic s_accept, load_out, match, drop_left, drop_right, take_pair;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign s_accept      = s_axis_tvalid && s_axis_tready;

  stp_side_fifo #(.DEPTH(QUEUE_DEPTH)) u_left (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (lf_ctrl),
    .push_data_i(s_axis_tdata),
    .head_data_o(l_head),
    .full_o     (l_full),
    .nonempty_o (l_nonempty)
  );

  stp_side_fifo #(.DEPTH(QUEUE_DEPTH)) u_right (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (rf_ctrl),
    .push_data_i(s_axis_tdata),
    .head_data_o(r_head),
    .full_o     (r_full),
    .nonempty_o (r_nonempty)
  );

  stp_alu u_alu (
    .op_i  (alu_op),
    .tl_i  (l_head[TimeW-1:0]),
    .tr_i  (r_head[TimeW-1:0]),
    .diff_i(diff_q),
    .tol_i (tol_q),
    .sum_o (alu_sum)
  );

  assign match = diff_q[SumW-1] ? !alu_sum[SumW-1]
               : ((diff_q[TimeW-1:TolW] == '0) && (diff_q[TolW-1:0] <= tol_q));

  always_comb begin
    state_d    = state_q;
    alu_op     = ALU_ADD;
    drop_left  = 1'b0;
    drop_right = 1'b0;
    take_pair  = 1'b0;
    load_out   = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (s_accept) begin
          state_d = ST_LOAD;
        end
      end
      ST_LOAD: begin
        state_d = (l_nonempty && r_nonempty) ? ST_DIFF : ST_OUT;
      end
      ST_DIFF: begin
        alu_op  = ALU_SUB;
        state_d = ST_TOL;
      end
      ST_TOL: begin
        alu_op = ALU_TOL;
        if (match) begin
          state_d = ST_MID;
        end else begin
          drop_left  = diff_q[SumW-1];
          drop_right = !diff_q[SumW-1];
          state_d    = ST_LOAD;
        end
      end
      ST_MID: begin
        take_pair = 1'b1;
        state_d   = ST_OUT;
      end
      ST_OUT: begin
        if (!m_valid_q || m_axis_tready) begin
          load_out = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
    lf_ctrl.push = s_accept && !s_axis_tuser;
    rf_ctrl.push = s_accept && s_axis_tuser;
    lf_ctrl.pop  = drop_left || take_pair;
    rf_ctrl.pop  = drop_right || take_pair;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      tol_q     <= TolReset;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        tol_q <= cfg_wdata_i;
      end
      if (load_out) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      ovf_q    <= s_axis_tuser ? r_full : l_full;
      ldrop_q  <= '0;
      rdrop_q  <= '0;
      paired_q <= 1'b0;
      ltag_q   <= '0;
      rtag_q   <= '0;
      mid_q    <= '0;
    end
    if (state_q == ST_DIFF) begin
      diff_q <= alu_sum;
    end
    if (drop_left) begin
      ldrop_q <= ldrop_q + DropW'(1);
    end
    if (drop_right) begin
      rdrop_q <= rdrop_q + DropW'(1);
    end
    if (take_pair) begin
      paired_q <= 1'b1;
      ltag_q   <= l_head[EntryW-1:TimeW];
      rtag_q   <= r_head[EntryW-1:TimeW];
      mid_q    <= alu_sum[SumW-1:1];
    end
    if (load_out) begin
      m_data_q <= {{(OutDataW - 91){1'b0}}, ovf_q, rdrop_q, ldrop_q, mid_q, rtag_q, ltag_q};
      m_user_q <= paired_q;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

endmodule

// ===== sv/stp_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module stp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/stp_side_fifo.sv =====
// Circular timestamp and tag queue of one camera side, head read through a RAM.
module stp_side_fifo
  import stp_pkg::*;
#(
  parameter int unsigned DEPTH = QueueDepthDefault
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  fifo_ctrl_t                 ctrl_i,
  input  logic [EntryW-1:0]          push_data_i,
  output logic [EntryW-1:0]          head_data_o,
  output logic                       full_o,
  output logic                       nonempty_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [AW-1:0] head_q, head_d, head_inc;
  logic [CW-1:0] count_q, count_d;
  logic [CW:0]   pos_sum;
  logic [AW-1:0] waddr;

  assign full_o     = (count_q == CW'(DEPTH));
  assign nonempty_o = (count_q != '0);
  assign head_inc   = (head_q == AW'(DEPTH - 1)) ? '0 : head_q + AW'(1);

  always_comb begin
    pos_sum = {{(CW + 1 - AW){1'b0}}, head_q} + {1'b0, count_q};
    if (pos_sum >= (CW + 1)'(DEPTH)) begin
      pos_sum = pos_sum - (CW + 1)'(DEPTH);
    end
    waddr = pos_sum[AW-1:0];
  end

  always_comb begin
    head_d  = head_q;
    count_d = count_q;
    if (ctrl_i.push) begin
      if (full_o) begin
        head_d = head_inc;
      end else begin
        count_d = count_q + CW'(1);
      end
    end else if (ctrl_i.pop && nonempty_o) begin
      head_d  = head_inc;
      count_d = count_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      count_q <= '0;
    end else begin
      head_q  <= head_d;
      count_q <= count_d;
    end
  end

  stp_ram #(
    .WIDTH(EntryW),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ctrl_i.push),
    .waddr_i(waddr),
    .wdata_i(push_data_i),
    .raddr_i(head_q),
    .rdata_o(head_data_o)
  );

endmodule

// ===== sv/stp_alu.sv =====
// Shared 65-bit adder: head difference, tolerance test and midpoint sum.
module stp_alu
  import stp_pkg::*;
(
  input  alu_op_e          op_i,
  input  logic [TimeW-1:0] tl_i,
  input  logic [TimeW-1:0] tr_i,
  input  logic [SumW-1:0]  diff_i,
  input  logic [TolW-1:0]  tol_i,
  output logic [SumW-1:0]  sum_o
);

  logic [SumW-1:0] opa, opb;
  logic            cin;

  always_comb begin
    unique case (op_i)
      ALU_SUB: begin
        opa = {1'b0, tl_i};
        opb = ~{1'b0, tr_i};
        cin = 1'b1;
      end
      ALU_TOL: begin
        opa = diff_i;
        opb = {{(SumW - TolW){1'b0}}, tol_i};
        cin = 1'b0;
      end
      default: begin
        opa = {1'b0, tl_i};
        opb = {1'b0, tr_i};
        cin = 1'b0;
      end
    endcase
  end

  assign sum_o = opa + opb + {{(SumW - 1){1'b0}}, cin};

endmodule

// ===== sv/stp_checker.sv =====
// Port-level checks of the stereo timestamp pairer and their bind to the top level.
module stp_checker
  import stp_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                s_axis_tvalid,
  input logic                s_axis_tready,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready,
  input logic [OutDataW-1:0] m_axis_tdata,
  input logic                m_axis_tuser
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("output changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken again before the item was processed");

  a_no_pair_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[79:0] == '0)
    else $error("unpaired result carries tags or time");

  a_result_from_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
    else $error("result appeared without a processed item");

endmodule

bind stereo_timestamp_pairer_top stp_checker u_stp_checker (.*);
